// ----- hw/rtl/mbgs_pkg.sv -----
// shared constants of the masked bilinear grid sampler
package mbgs_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_TILE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_TILE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_NODATA      = 2'd2;
   localparam logic [1:0] CSR_MASK_EN     = 2'd3;

   // transaction modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // reset values of the configuration registers
   localparam logic [6:0]  RST_TILE_WIDTH  = 7'd64;
   localparam logic [6:0]  RST_TILE_HEIGHT = 7'd64;
   localparam logic [31:0] RST_NODATA      = 32'h8000_0000;

   // acceptance thresholds: weighted mask above 85 percent
   localparam int MASK_SCALE = 100;
   localparam int MASK_LIMIT = 85;

   // quotient width and saturation bounds
   localparam int          QUOT_W    = 32;
   localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;

endpackage

// ----- hw/rtl/mbgs_bank.sv -----
// one bank of the sample store: one write port, one registered read port
module mbgs_bank #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 33
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_ff [0:(1<<ADDR_W)-1];
   logic [DATA_W-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/masked_bilinear_grid_sampler.sv -----
// top level of the masked bilinear grid sampler
//
// A transaction is taken on the req_ ports at a rising edge where start is
// high and busy is low; busy stays low, so one transaction may enter every
// cycle. A write transaction (req_mode 0) stores one cell value and mask
// bit and gives no result. A query transaction (req_mode 1) gives exactly
// one result: rsp_strobe is high for one cycle with rsp_height_value and
// rsp_valid_res. Results leave in the order the queries came in; the
// receiver cannot hold them off.
// Throughput is one transaction per cycle: the store is split into four
// banks by row and column parity, so the four corners of a query are read
// in parallel, and the division by the weight sum runs in a 32-stage
// pipelined restoring divider, one quotient bit per stage.
// A write is visible to every query accepted after it. Reset clears the
// pipeline and the configuration registers; the sample store is not cleared
// and a cell must be written before it is read. Configuration goes through
// the APB-style port (psel..pready) at byte addresses 0, 4, 8 and 12; the
// user must see it written only while the block is idle; this is not enforced.
module masked_bilinear_grid_sampler
   import mbgs_pkg::*;
#(
   parameter int TILE_COLS       = 64,
   parameter int TILE_ROWS       = 64,
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic [11:0]        req_cell_address,
   input  logic signed [31:0] req_cell_value,
   input  logic               req_cell_mask,
   input  logic signed [15:0] req_query_x,
   input  logic signed [15:0] req_query_y,
   // result channel
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_height_value,
   output logic               rsp_valid_res,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int F     = COORD_FRAC_BITS;
   localparam int FW    = F + 1;
   localparam int DW    = 2 * F + 1;
   localparam int PW    = 33 + DW;
   localparam int ACCW  = PW + 2;
   localparam int NW    = 32 + DW;
   localparam int TW    = DW + 9;
   localparam int CW    = $clog2(TILE_COLS);
   localparam int RW    = $clog2(TILE_ROWS);
   localparam int CHW   = (CW > 1) ? CW - 1 : 1;
   localparam int RHW   = (RW > 1) ? RW - 1 : 1;
   localparam int BAW   = CHW + RHW;
   localparam int SWW   = $clog2(TILE_COLS + 1);
   localparam int SHW   = $clog2(TILE_ROWS + 1);
   localparam int STORE_DEPTH = TILE_COLS * TILE_ROWS;
   localparam int RECIP = ((1 << 24) + TILE_COLS - 1) / TILE_COLS;
   localparam int NDIV  = QUOT_W;

   // configuration registers
   logic [6:0]  tw_ff, th_ff;
   logic [31:0] nd_ff;
   logic        me_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff <= RST_TILE_WIDTH;
         th_ff <= RST_TILE_HEIGHT;
         nd_ff <= RST_NODATA;
         me_ff <= 1'b0;
      end else if (csr_wr) begin
         case (paddr[3:2])
            CSR_TILE_WIDTH:  tw_ff <= pwdata[6:0];
            CSR_TILE_HEIGHT: th_ff <= pwdata[6:0];
            CSR_NODATA:      nd_ff <= pwdata;
            CSR_MASK_EN:     me_ff <= pwdata[0];
            default:         tw_ff <= tw_ff;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (paddr[3:2])
         CSR_TILE_WIDTH:  prdata = {25'd0, tw_ff};
         CSR_TILE_HEIGHT: prdata = {25'd0, th_ff};
         CSR_NODATA:      prdata = nd_ff;
         CSR_MASK_EN:     prdata = {31'd0, me_ff};
         default:         prdata = 32'd0;
      endcase
   end

   assign busy = 1'b0;

   // input register
   logic        a_vld_ff, a_mode_ff, a_mask_ff;
   logic [11:0] a_addr_ff;
   logic [31:0] a_value_ff;
   logic [15:0] a_qx_ff, a_qy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      a_mode_ff  <= req_mode;
      a_addr_ff  <= req_cell_address;
      a_value_ff <= req_cell_value;
      a_mask_ff  <= req_cell_mask;
      a_qx_ff    <= req_query_x;
      a_qy_ff    <= req_query_y;
   end

   // clamped tile size
   logic [SWW-1:0] size_x;
   logic [SHW-1:0] size_y;

   always_comb begin
      if ({25'd0, tw_ff} < 32'd2) size_x = SWW'(2);
      else if ({25'd0, tw_ff} > 32'(TILE_COLS)) size_x = SWW'(TILE_COLS);
      else size_x = SWW'(tw_ff);
      if ({25'd0, th_ff} < 32'd2) size_y = SHW'(2);
      else if ({25'd0, th_ff} > 32'(TILE_ROWS)) size_y = SHW'(TILE_ROWS);
      else size_y = SHW'(th_ff);
   end

   // write address split into row and column by reciprocal multiply
   logic [36:0]    wq_prod;
   logic [12:0]    wq;
   logic [11:0]    wrem;
   logic [RW-1:0]  w_row;
   logic [CW-1:0]  w_col;
   logic [RW-1:0]  w_row_half;
   logic [CW-1:0]  w_col_half;
   logic [1:0]     w_bank;
   logic [BAW-1:0] w_addr;
   logic           w_en;

   always_comb begin
      wq_prod    = {25'd0, a_addr_ff} * 37'(RECIP);
      wq         = wq_prod[36:24];
      wrem       = a_addr_ff - 12'(wq * 13'(TILE_COLS));
      w_row      = wq[RW-1:0];
      w_col      = wrem[CW-1:0];
      w_row_half = w_row >> 1;
      w_col_half = w_col >> 1;
      w_bank     = {w_row[0], w_col[0]};
      w_addr     = {w_row_half[RHW-1:0], w_col_half[CHW-1:0]};
      w_en       = a_vld_ff && (a_mode_ff == MODE_WRITE)
                   && ({20'd0, a_addr_ff} < 32'(STORE_DEPTH));
   end

   // query axis split: left/top index and fraction per axis
   logic signed [17:0] dx, dy;
   logic [SWW+F-1:0]   dmax_x;
   logic [SHW+F-1:0]   dmax_y;
   logic               out_x, out_y, edge_x, edge_y;
   logic [16:0]        shx, shy;
   logic [CW-1:0]      ix;
   logic [RW-1:0]      iy;
   logic [FW-1:0]      fx_in, fy_in;
   logic [CW:0]        ixp1, ce_full, co_full;
   logic [RW:0]        iyp1, re_full, ro_full;
   logic [BAW-1:0]     rd_addr [0:3];

   always_comb begin
      dx     = {{2{a_qx_ff[15]}}, a_qx_ff} - 18'(1 << (F - 1));
      dy     = {{2{a_qy_ff[15]}}, a_qy_ff} - 18'(1 << (F - 1));
      dmax_x = (SWW+F)'(size_x - SWW'(1)) << F;
      dmax_y = (SHW+F)'(size_y - SHW'(1)) << F;
      out_x  = dx[17] || ({{(SWW+F){1'b0}}, dx[16:0]} > {17'd0, dmax_x});
      out_y  = dy[17] || ({{(SHW+F){1'b0}}, dy[16:0]} > {17'd0, dmax_y});
      edge_x = {{(SWW+F){1'b0}}, dx[16:0]} == {17'd0, dmax_x};
      edge_y = {{(SHW+F){1'b0}}, dy[16:0]} == {17'd0, dmax_y};
      shx    = dx[16:0] >> F;
      shy    = dy[16:0] >> F;
      ix     = edge_x ? CW'(size_x - SWW'(2)) : shx[CW-1:0];
      iy     = edge_y ? RW'(size_y - SHW'(2)) : shy[RW-1:0];
      fx_in  = edge_x ? FW'(1 << F) : {1'b0, dx[F-1:0]};
      fy_in  = edge_y ? FW'(1 << F) : {1'b0, dy[F-1:0]};
      // the even bank holds (i+1)/2 and the odd bank i/2
      ixp1    = {1'b0, ix} + 1'b1;
      ce_full = ixp1 >> 1;
      co_full = {1'b0, ix} >> 1;
      iyp1    = {1'b0, iy} + 1'b1;
      re_full = iyp1 >> 1;
      ro_full = {1'b0, iy} >> 1;
      rd_addr[0] = {re_full[RHW-1:0], ce_full[CHW-1:0]};
      rd_addr[1] = {re_full[RHW-1:0], co_full[CHW-1:0]};
      rd_addr[2] = {ro_full[RHW-1:0], ce_full[CHW-1:0]};
      rd_addr[3] = {ro_full[RHW-1:0], co_full[CHW-1:0]};
   end

   // four parity banks of the sample store
   logic [32:0] rd_data [0:3];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      mbgs_bank #(
         .ADDR_W (BAW),
         .DATA_W (33)
      ) u_bank (
         .clock   (clock),
         .wr_en   (w_en && (w_bank == 2'(b))),
         .wr_addr (w_addr),
         .wr_data ({a_mask_ff, a_value_ff}),
         .rd_addr (rd_addr[b]),
         .rd_data (rd_data[b])
      );
   end

   // stage b: query state alongside the memory read
   logic          b_vld_ff, b_out_ff, b_ix0_ff, b_iy0_ff;
   logic [FW-1:0] b_fx_ff, b_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff && (a_mode_ff == MODE_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      b_out_ff <= out_x || out_y;
      b_ix0_ff <= ix[0];
      b_iy0_ff <= iy[0];
      b_fx_ff  <= fx_in;
      b_fy_ff  <= fy_in;
   end

   // stage c: corner weights, nodata corners dropped
   logic               c_vld_ff, c_out_ff;
   logic signed [31:0] c_val_ff [0:3];
   logic [DW-1:0]      c_wt_ff [0:3];
   logic               c_m_ff [0:3];
   logic [FW-1:0]      wx_in [0:3];
   logic [FW-1:0]      wy_in [0:3];
   logic [2*FW-1:0]    wt_in [0:3];
   logic [32:0]        cd_in [0:3];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cd_in[k] = rd_data[{b_iy0_ff ^ k[1], b_ix0_ff ^ k[0]}];
         wx_in[k] = k[0] ? b_fx_ff : FW'(1 << F) - b_fx_ff;
         wy_in[k] = k[1] ? b_fy_ff : FW'(1 << F) - b_fy_ff;
         wt_in[k] = wx_in[k] * wy_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_out_ff <= b_out_ff;
      for (int k = 0; k < 4; k++) begin
         c_val_ff[k] <= cd_in[k][31:0];
         c_m_ff[k]   <= me_ff ? cd_in[k][32] : 1'b1;
         c_wt_ff[k]  <= (cd_in[k][31:0] == nd_ff) ? DW'(0) : wt_in[k][DW-1:0];
      end
   end

   // stage d: weighted values and weight sums
   logic                 d_vld_ff, d_out_ff;
   logic signed [PW-1:0] d_prod_ff [0:3];
   logic [DW+1:0]        d_wsum_ff, d_msum_ff;
   logic [DW+1:0]        wsum_in, msum_in;

   always_comb begin
      wsum_in = '0;
      msum_in = '0;
      for (int k = 0; k < 4; k++) begin
         wsum_in = wsum_in + (DW+2)'(c_wt_ff[k]);
         msum_in = msum_in + (c_m_ff[k] ? (DW+2)'(c_wt_ff[k]) : (DW+2)'(0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_out_ff  <= c_out_ff;
      d_wsum_ff <= wsum_in;
      d_msum_ff <= msum_in;
      for (int k = 0; k < 4; k++) begin
         d_prod_ff[k] <= c_val_ff[k] * $signed({1'b0, c_wt_ff[k]});
      end
   end

   // stage e: value sum and acceptance tests
   logic                   e_vld_ff, e_ok_ff;
   logic signed [ACCW-1:0] e_acc_ff;
   logic [DW-1:0]          e_wsum_ff;
   logic signed [ACCW-1:0] acc_in;
   logic                   ok_in;

   always_comb begin
      acc_in = '0;
      for (int k = 0; k < 4; k++) begin
         acc_in = acc_in + ACCW'(d_prod_ff[k]);
      end
      ok_in = !d_out_ff && (d_wsum_ff != '0)
              && (TW'(d_msum_ff) * TW'(MASK_SCALE) > TW'(d_wsum_ff) * TW'(MASK_LIMIT))
              && ((TW'(d_wsum_ff) << 1) > (TW'(1) << (2 * F)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      e_ok_ff   <= ok_in;
      e_acc_ff  <= acc_in;
      e_wsum_ff <= d_wsum_ff[DW-1:0];
   end

   // stage f: magnitude plus half divisor for rounding
   logic                f_vld_ff, f_ok_ff, f_neg_ff;
   logic [NW-1:0]       f_num_ff;
   logic [DW-1:0]       f_den_ff;
   logic [ACCW-1:0]     mag_in;

   always_comb begin
      mag_in = e_acc_ff[ACCW-1] ? ACCW'(-e_acc_ff) : ACCW'(e_acc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      f_ok_ff  <= e_ok_ff;
      f_neg_ff <= e_acc_ff[ACCW-1];
      f_num_ff <= mag_in[NW-1:0] + NW'(e_wsum_ff >> 1);
      f_den_ff <= e_wsum_ff;
   end

   // pipelined restoring divider, one quotient bit per stage
   logic              dv_vld_ff [1:NDIV];
   logic              dv_ok_ff  [1:NDIV];
   logic              dv_neg_ff [1:NDIV];
   logic [DW-1:0]     dv_rem_ff [1:NDIV];
   logic [DW-1:0]     dv_den_ff [1:NDIV];
   logic [QUOT_W-1:0] dv_lo_ff  [1:NDIV];
   logic [QUOT_W-1:0] dv_quo_ff [1:NDIV];

   for (genvar j = 0; j < NDIV; j++) begin : g_div
      logic              src_vld, src_ok, src_neg;
      logic [DW-1:0]     src_rem, src_den;
      logic [QUOT_W-1:0] src_lo, src_quo;
      logic [DW:0]       trial_in;
      logic              ge_in;

      // stage input: the rounded numerator first, then the previous stage
      if (j == 0) begin : g_first
         assign src_vld = f_vld_ff;
         assign src_ok  = f_ok_ff;
         assign src_neg = f_neg_ff;
         assign src_rem = f_num_ff[NW-1:QUOT_W];
         assign src_den = f_den_ff;
         assign src_lo  = f_num_ff[QUOT_W-1:0];
         assign src_quo = '0;
      end else begin : g_next
         assign src_vld = dv_vld_ff[j];
         assign src_ok  = dv_ok_ff[j];
         assign src_neg = dv_neg_ff[j];
         assign src_rem = dv_rem_ff[j];
         assign src_den = dv_den_ff[j];
         assign src_lo  = dv_lo_ff[j];
         assign src_quo = dv_quo_ff[j];
      end

      always_comb begin
         trial_in = {src_rem, src_lo[QUOT_W-1]};
         ge_in    = trial_in >= {1'b0, src_den};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j+1] <= 1'b0;
         end else begin
            dv_vld_ff[j+1] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         dv_ok_ff[j+1]  <= src_ok;
         dv_neg_ff[j+1] <= src_neg;
         dv_den_ff[j+1] <= src_den;
         dv_rem_ff[j+1] <= ge_in ? DW'(trial_in - {1'b0, src_den}) : trial_in[DW-1:0];
         dv_lo_ff[j+1]  <= src_lo << 1;
         dv_quo_ff[j+1] <= {src_quo[QUOT_W-2:0], ge_in};
      end
   end

   // saturation and output register
   logic              rsp_strobe_ff, rsp_valid_ff;
   logic [31:0]       rsp_value_ff;
   logic [31:0]       res_in;
   logic [QUOT_W-1:0] quo;

   always_comb begin
      quo = dv_quo_ff[NDIV];
      if (!dv_ok_ff[NDIV]) begin
         res_in = nd_ff;
      end else if (dv_neg_ff[NDIV]) begin
         res_in = 32'(-{1'b0, quo});
      end else if (quo > INT32_MAX) begin
         res_in = INT32_MAX;
      end else begin
         res_in = quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_vld_ff[NDIV];
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= res_in;
      rsp_valid_ff <= dv_ok_ff[NDIV] && (res_in != nd_ff);
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_height_value = rsp_value_ff;
   assign rsp_valid_res    = rsp_valid_ff;

endmodule
